>>> rtl/fdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the finite difference derivative core
// Register indexes, stencil kinds, tap coefficients and fixed field widths.
// ----------------------------------------------------------------------------
package fdd_pkg;

	// fixed field widths
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int ORDER_WIDTH     = 3;
	localparam int INDEX_WIDTH     = 16;
	localparam int SCALE_WIDTH     = 32;
	localparam int COEF_WIDTH      = 8;
	// magnitude headroom of a stencil sum over one sample
	localparam int SUM_GROWTH      = 8;

	// window and stencil geometry
	localparam int WINDOW_DEPTH = 9;
	localparam int NUM_TAPS     = 9;
	localparam int NUM_ORDERS   = 4;
	localparam int NUM_KINDS    = 3;

	// frame length limits
	localparam logic [INDEX_WIDTH-1:0] MIN_GRID_LENGTH = 16'd8;
	localparam logic [INDEX_WIDTH-1:0] MAX_GRID_LENGTH = 16'd65535;

	// points emitted by the sample that closes a frame, minus one
	localparam logic [2:0] FLUSH_LAST_OFF = 3'd4;
	// distance between the newest sample and the point it releases
	localparam logic [INDEX_WIDTH-1:0] RELEASE_LAG = 16'd4;

	// configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ORDER          = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_GRID_LENGTH    = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOUNDARY_SCALE = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERIOR_SCALE = 2'd3;

	// stencil kind
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FWD = 2'd0;
	localparam kind_t KIND_BWD = 2'd1;
	localparam kind_t KIND_CEN = 2'd2;

	// coefficients for offsets -4..+4, per order and kind
	localparam logic signed [COEF_WIDTH-1:0] TAP_COEF [NUM_ORDERS][NUM_KINDS][NUM_TAPS] = '{
		'{ '{0,0,0,0,-1,1,0,0,0}, '{0,0,0,-1,1,0,0,0,0}, '{0,0,1,-8,0,8,-1,0,0} },
		'{ '{0,0,0,0,1,-2,1,0,0}, '{0,0,1,-2,1,0,0,0,0}, '{0,0,-1,16,-30,16,-1,0,0} },
		'{ '{0,0,0,0,-1,3,-3,1,0}, '{0,-1,3,-3,1,0,0,0,0}, '{0,1,-8,13,0,-13,8,-1,0} },
		'{ '{0,0,0,0,1,-4,6,-4,1}, '{1,-4,6,-4,1,0,0,0,0}, '{0,-1,12,-39,56,-39,12,-1,0} }
	};

	// coefficient lookup, unused kind code falls on the central stencil
	function automatic logic signed [COEF_WIDTH-1:0] tap_coef(
		input logic [1:0] ord_sel,
		input kind_t      kind,
		input logic [3:0] tap
	);
		logic signed [COEF_WIDTH-1:0] c;
		case (kind)
			KIND_FWD: c = TAP_COEF[ord_sel][0][tap];
			KIND_BWD: c = TAP_COEF[ord_sel][1][tap];
			default:  c = TAP_COEF[ord_sel][2][tap];
		endcase
		return c;
	endfunction

endpackage

>>> rtl/finite_difference_derivative_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// finite_difference_derivative_core: streaming fourth order derivative
// Shifts Q16.16 samples into a nine deep window and emits the selected
// derivative of each grid point, central inside, one sided near the ends.
//
//  channel   signals                                  request
//  --------  ---------------------------------------  ----------------------
//  in        in_valid, in_stall, sample               one grid sample
//  out       out_valid, out_stall, derivative,        one point result
//            point_index, last_of_frame
//  cfg       cfg_we, cfg_index, cfg_data              one register write
//
// One sample per cycle while in_stall is low. Stages: tap products, stencil
// sum, two partial scale products, round and clamp. The sample that closes
// a frame issues five points from the frozen window, so in_stall stays high
// until the last of them issues. Stalls travel back stage by stage; empty
// stages keep filling. Reset clears the window, the sample count and
// all valid bits.
// ----------------------------------------------------------------------------
module finite_difference_derivative_core #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [fdd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [fdd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	// samples in
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample,
	// results out
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       derivative,
	output logic [fdd_pkg::INDEX_WIDTH-1:0]      point_index,
	output logic                                 last_of_frame
);
	import fdd_pkg::*;

	localparam int PRW = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int MW  = SAMPLE_WIDTH + SUM_GROWTH;
	localparam int PW  = MW + 16;

	// configuration registers
	logic [ORDER_WIDTH-1:0] order_q;
	logic [INDEX_WIDTH-1:0] grid_len_q;
	logic [SCALE_WIDTH-1:0] bscale_q;
	logic [SCALE_WIDTH-1:0] iscale_q;

	// window and frame position
	logic signed [SAMPLE_WIDTH-1:0] win_q [WINDOW_DEPTH];
	logic [INDEX_WIDTH-1:0]         count_q;

	// issue stage
	logic                   iss_v_q;
	logic [2:0]             iss_off_q;
	logic                   iss_flush_q;
	logic [INDEX_WIDTH-1:0] iss_p_q;
	logic [INDEX_WIDTH-1:0] iss_len_q;

	// stage 1: tap products
	logic                   v_s1;
	logic signed [PRW-1:0]  prod_s1 [NUM_TAPS];
	kind_t                  kind_s1;
	logic [INDEX_WIDTH-1:0] p_s1;
	logic                   last_s1;

	// stage 2: magnitude of the stencil sum
	logic                   v_s2;
	logic [MW-1:0]          mag_s2;
	logic                   neg_s2;
	logic [SCALE_WIDTH-1:0] scale_s2;
	logic [INDEX_WIDTH-1:0] p_s2;
	logic                   last_s2;

	// stage 3: partial scale products
	logic                   v_s3;
	logic [PW-1:0]          phi_s3;
	logic [PW-1:0]          plo_s3;
	logic                   neg_s3;
	logic [INDEX_WIDTH-1:0] p_s3;
	logic                   last_s3;

	// output register
	logic                    out_v_q;
	logic [SAMPLE_WIDTH-1:0] deriv_q;
	logic [INDEX_WIDTH-1:0]  pidx_q;
	logic                    last_q;

	// combinational
	logic                   rdy_out, rdy3, rdy2, rdy1;
	logic                   iss_go, flush_more, accept;
	logic [1:0]             ord_sel;
	logic [1:0]             edge_pts;
	logic [INDEX_WIDTH-1:0] len_eff;
	logic                   closes;
	kind_t                  iss_kind;
	logic signed [PRW-1:0]  prod_c [NUM_TAPS];
	logic signed [MW-1:0]   sum_c;
	logic [SAMPLE_WIDTH-1:0] result_c;

	// order clamp and end zone width
	always_comb begin
		if (order_q == '0)
			ord_sel = 2'd0;
		else if (order_q > 3'd4)
			ord_sel = 2'd3;
		else
			ord_sel = 2'(order_q - 3'd1);
		edge_pts = (ord_sel <= 2'd1) ? 2'd2 : 2'd3;
	end

	// effective frame length and frame close test
	always_comb begin
		if (grid_len_q < MIN_GRID_LENGTH)
			len_eff = MIN_GRID_LENGTH;
		else if (grid_len_q > MAX_GRID_LENGTH)
			len_eff = MAX_GRID_LENGTH;
		else
			len_eff = grid_len_q;
		closes = ({1'b0, count_q} + 17'd1) >= {1'b0, len_eff};
	end

	// backpressure chain
	assign rdy_out    = !out_v_q || !out_stall;
	assign rdy3       = !v_s3 || rdy_out;
	assign rdy2       = !v_s2 || rdy3;
	assign rdy1       = !v_s1 || rdy2;
	assign iss_go     = iss_v_q && rdy1;
	assign flush_more = iss_flush_q && (iss_off_q != FLUSH_LAST_OFF);
	assign in_stall   = iss_v_q && (!rdy1 || flush_more);
	assign accept     = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q    <= 3'd1;
			grid_len_q <= 16'd64;
			bscale_q   <= 32'd65536;
			iscale_q   <= 32'd5461;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORDER:          order_q    <= cfg_data[ORDER_WIDTH-1:0];
				REG_GRID_LENGTH:    grid_len_q <= cfg_data[INDEX_WIDTH-1:0];
				REG_BOUNDARY_SCALE: bscale_q   <= cfg_data[SCALE_WIDTH-1:0];
				REG_INTERIOR_SCALE: iscale_q   <= cfg_data[SCALE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// sample window and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++)
				win_q[i] <= '0;
			count_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[WINDOW_DEPTH-1] <= sample;
			count_q <= closes ? '0 : count_q + 1'b1;
		end
	end

	// issue token: one point per request from the fifth of a frame on, five on the closing request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_v_q     <= 1'b0;
			iss_off_q   <= '0;
			iss_flush_q <= 1'b0;
			iss_p_q     <= '0;
			iss_len_q   <= '0;
		end else if (accept) begin
			iss_v_q     <= closes || (count_q >= RELEASE_LAG);
			iss_off_q   <= '0;
			iss_flush_q <= closes;
			iss_p_q     <= count_q - RELEASE_LAG;
			iss_len_q   <= closes ? count_q + 1'b1 : len_eff;
		end else if (iss_go) begin
			if (flush_more) begin
				iss_off_q <= iss_off_q + 1'b1;
				iss_p_q   <= iss_p_q + 1'b1;
			end else begin
				iss_v_q <= 1'b0;
			end
		end
	end

	// stencil kind of the issued point
	always_comb begin
		if (iss_p_q < {14'd0, edge_pts})
			iss_kind = KIND_FWD;
		else if (({1'b0, iss_p_q} + 17'(edge_pts)) >= {1'b0, iss_len_q})
			iss_kind = KIND_BWD;
		else
			iss_kind = KIND_CEN;
	end

	fdd_stencil #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_stencil (
		.window  (win_q),
		.offset  (iss_off_q),
		.ord_sel (ord_sel),
		.kind    (iss_kind),
		.prod    (prod_c)
	);

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= iss_go;
		end
	end

	always_ff @(posedge clk) begin
		if (iss_go) begin
			prod_s1 <= prod_c;
			kind_s1 <= iss_kind;
			p_s1    <= iss_p_q;
			last_s1 <= iss_flush_q && (iss_off_q == FLUSH_LAST_OFF);
		end
	end

	// stencil sum
	always_comb begin
		sum_c = '0;
		for (int t = 0; t < NUM_TAPS; t++)
			sum_c = sum_c + MW'(prod_s1[t]);
	end

	// stage 2 register: sign, magnitude and scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			neg_s2   <= sum_c[MW-1];
			mag_s2   <= sum_c[MW-1] ? MW'(-sum_c) : MW'(sum_c);
			scale_s2 <= (kind_s1 == KIND_CEN) ? iscale_q : bscale_q;
			p_s2     <= p_s1;
			last_s2  <= last_s1;
		end
	end

	// stage 3 register: magnitude times each half of the scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			phi_s3  <= PW'(mag_s2) * PW'(scale_s2[SCALE_WIDTH-1:16]);
			plo_s3  <= PW'(mag_s2) * PW'(scale_s2[15:0]);
			neg_s3  <= neg_s2;
			p_s3    <= p_s2;
			last_s3 <= last_s2;
		end
	end

	fdd_round_sat #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_round_sat (
		.prod_hi (phi_s3),
		.prod_lo (plo_s3),
		.neg     (neg_s3),
		.result  (result_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			deriv_q <= result_c;
			pidx_q  <= p_s3;
			last_q  <= last_s3;
		end
	end

	assign out_valid     = out_v_q;
	assign derivative    = deriv_q;
	assign point_index   = pidx_q;
	assign last_of_frame = last_q;

endmodule

>>> rtl/fdd_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_stencil: tap selection and coefficient products
// Picks nine taps around the chosen window position and weights each one.
// ----------------------------------------------------------------------------
module fdd_stencil #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic signed [SAMPLE_WIDTH-1:0] window [fdd_pkg::WINDOW_DEPTH],
	input  logic [2:0]                     offset,
	input  logic [1:0]                     ord_sel,
	input  fdd_pkg::kind_t                 kind,
	output logic signed [SAMPLE_WIDTH+fdd_pkg::COEF_WIDTH-1:0] prod [fdd_pkg::NUM_TAPS]
);
	import fdd_pkg::*;

	// one weighted tap per stencil offset, taps past the newest sample read zero
	for (genvar t = 0; t < NUM_TAPS; t++) begin : g_tap
		logic [3:0]                     idx;
		logic signed [SAMPLE_WIDTH-1:0] tap;
		logic signed [COEF_WIDTH-1:0]   coef;

		assign idx  = {1'b0, offset} + 4'(t);
		assign tap  = (idx < 4'(WINDOW_DEPTH)) ? window[idx] : '0;
		assign coef = tap_coef(ord_sel, kind, 4'(t));
		assign prod[t] = tap * coef;
	end

endmodule

>>> rtl/fdd_round_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_round_sat: scale recombination, rounding and saturation
// Joins the two partial scale products, rounds half away from zero, clamps.
// ----------------------------------------------------------------------------
module fdd_round_sat #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic [SAMPLE_WIDTH+fdd_pkg::SUM_GROWTH+15:0] prod_hi,
	input  logic [SAMPLE_WIDTH+fdd_pkg::SUM_GROWTH+15:0] prod_lo,
	input  logic                                         neg,
	output logic [SAMPLE_WIDTH-1:0]                      result
);
	import fdd_pkg::*;

	localparam int PW = SAMPLE_WIDTH + SUM_GROWTH + 16;
	localparam logic [PW:0] LIM     = {{(PW + 2 - SAMPLE_WIDTH){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [PW:0] LIM_NEG = LIM + 1'b1;

	logic [PW:0] lo_rnd;
	logic [PW:0] mag;
	logic [PW:0] mag_neg;

	// magnitude times scale, fraction rounded at bit 15
	assign lo_rnd  = {1'b0, prod_lo} + (PW+1)'(32'h8000);
	assign mag     = {1'b0, prod_hi} + (PW+1)'(lo_rnd[PW:16]);
	assign mag_neg = ~mag + 1'b1;

	// clamp to the signed sample range
	always_comb begin
		if (neg) begin
			if (mag > LIM_NEG)
				result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			else
				result = mag_neg[SAMPLE_WIDTH-1:0];
		end else begin
			if (mag > LIM)
				result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			else
				result = mag[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
